// ----- hw/rtl/crfm_pkg.sv -----
// Shared types, constants and register codes of the foliage metrics block.
`default_nettype none

package crfm_pkg;

	// Frame geometry limits; counters saturate here
	localparam int unsigned MAX_ROWS = 4096;
	localparam int unsigned MAX_COLS = 4096;

	// Field widths
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned LINE_W  = 13;
	localparam int unsigned COUNT_W = 25;
	localparam int unsigned TOP_W   = 14;
	localparam int unsigned DIFF_W  = 26;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 13;

	// Stream payload widths
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 104;

	localparam logic [COUNT_W-1:0] FRAME_MAX = COUNT_W'(MAX_ROWS * MAX_COLS);
	localparam logic [LINE_W-1:0]  ROW_MAX   = LINE_W'(MAX_ROWS);
	localparam logic [LINE_W-1:0]  COL_MAX   = LINE_W'(MAX_COLS);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLUE_LOW   = 3'd0,
		CFG_GREEN_LOW  = 3'd1,
		CFG_RED_LOW    = 3'd2,
		CFG_BLUE_HIGH  = 3'd3,
		CFG_GREEN_HIGH = 3'd4,
		CFG_RED_HIGH   = 3'd5,
		CFG_ROW_THRESH = 3'd6
	} cfg_idx_t;

	// Live configuration
	typedef struct packed {
		logic [LINE_W-1:0] row_hit_threshold;
		logic [CHAN_W-1:0] red_high;
		logic [CHAN_W-1:0] green_high;
		logic [CHAN_W-1:0] blue_high;
		logic [CHAN_W-1:0] red_low;
		logic [CHAN_W-1:0] green_low;
		logic [CHAN_W-1:0] blue_low;
	} cfg_t;

	// One pixel item with its marks
	typedef struct packed {
		logic              take_as_reference;
		logic              frame_end;
		logic              row_end;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	// One frame result; foliage_count sits in the lowest bits
	typedef struct packed {
		logic signed [DIFF_W-1:0] count_change;
		logic signed [TOP_W-1:0]  height_change;
		logic signed [TOP_W-1:0]  top_row;
		logic [COUNT_W-1:0]       pixel_total;
		logic [COUNT_W-1:0]       foliage_count;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/color_range_foliage_metrics.sv -----
// Top level of the foliage metrics block: stream ports, input and result registers.
// Usage:
//   s_* carries one BGR pixel per item in raster order. s_tdata holds blue, green,
//   red; s_tlast marks the last pixel of a row; s_tuser[0] marks the last pixel of
//   the frame and s_tuser[1] asks to keep that frame as the new reference.
//   m_* carries one item per frame: foliage count, pixel total, top row (-1 if no
//   row reaches the threshold), reference top minus top row, and foliage count
//   minus reference count.
//   cfg_* writes the color bounds and the row threshold; cfg_ready is always high.
//   Write configuration only while no frame is in flight.
// Timing:
//   One pixel is accepted per cycle unless a frame-end pixel waits in the input
//   register for a busy result slot. A pixel is counted as it leaves the input
//   register; when the last pixel of a frame leaves, the counter update between the
//   input register and the result register loads the frame result onto m_tvalid.
// Reset and stall:
//   Reset clears counters, reference (top -1, count 0) and loads default bounds.
//   While a result waits on m_tready, row pixels keep flowing; only a further
//   frame-end pixel waits in the input register, and s_tready drops behind it.
`default_nettype none

module color_range_foliage_metrics (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output      logic                               s_tready,
	input  wire logic [crfm_pkg::IN_DATA_W-1:0]     s_tdata,  // blue, green, red
	input  wire logic                               s_tlast,  // row_end
	input  wire logic [crfm_pkg::IN_USER_W-1:0]     s_tuser,  // frame_end, take_as_reference
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	// foliage_count, pixel_total, top_row, height_change, count_change
	output      logic [crfm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  wire logic                               cfg_valid,
	output      logic                               cfg_ready,
	input  wire logic [crfm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [crfm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	crfm_pkg::cfg_t cfg;
	crfm_pkg::pix_t pix_s1;
	crfm_pkg::res_t res, res_q;
	logic           valid_s1, out_valid_q;
	logic           out_free, step;

	assign cfg_ready = 1'b1;

	crfm_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Advance the held item unless it ends a frame and the result slot is taken
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!pix_s1.frame_end || out_free);
	assign s_tready = !valid_s1 || step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1.blue              <= s_tdata[7:0];
			pix_s1.green             <= s_tdata[15:8];
			pix_s1.red               <= s_tdata[23:16];
			pix_s1.row_end           <= s_tlast;
			pix_s1.frame_end         <= s_tuser[0];
			pix_s1.take_as_reference <= s_tuser[1];
		end
	end

	crfm_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.pix    (pix_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && pix_s1.frame_end) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && pix_s1.frame_end) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

`ifndef SYNTHESIS
	// An empty result slot never blocks the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty result slot");

	// A counted frame end always produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		step && pix_s1.frame_end |=> out_valid_q)
		else $error("frame end lost");

	// Foliage never exceeds the pixel total
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.foliage_count <= res_q.pixel_total)
		else $error("foliage count above pixel total");

	// Top row is either none or a valid row number
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.top_row == -14'sd1) ||
		                ((res_q.top_row >= 14'sd1) &&
		                 (res_q.top_row <= $signed(crfm_pkg::TOP_W'(crfm_pkg::MAX_ROWS)))))
		else $error("top row out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/crfm_cfg.sv -----
// Configuration register file of the foliage metrics block.
`default_nettype none

module crfm_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [crfm_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [crfm_pkg::CFG_DATA_W-1:0] wr_data,
	output crfm_pkg::cfg_t                       cfg
);

	crfm_pkg::cfg_t cfg_q;

	// Write one register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blue_low          <= 8'd0;
			cfg_q.green_low         <= 8'd10;
			cfg_q.red_low           <= 8'd0;
			cfg_q.blue_high         <= 8'd100;
			cfg_q.green_high        <= 8'd255;
			cfg_q.red_high          <= 8'd100;
			cfg_q.row_hit_threshold <= 13'd5;
		end else if (wr_en) begin
			unique case (crfm_pkg::cfg_idx_t'(wr_index))
				crfm_pkg::CFG_BLUE_LOW:   cfg_q.blue_low   <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_GREEN_LOW:  cfg_q.green_low  <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_RED_LOW:    cfg_q.red_low    <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_BLUE_HIGH:  cfg_q.blue_high  <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_GREEN_HIGH: cfg_q.green_high <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_RED_HIGH:   cfg_q.red_high   <= wr_data[crfm_pkg::CHAN_W-1:0];
				crfm_pkg::CFG_ROW_THRESH: cfg_q.row_hit_threshold <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/crfm_accum.sv -----
// Pixel classification and per-frame counters of the foliage metrics block.
`default_nettype none

module crfm_accum (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire crfm_pkg::pix_t pix,
	input  wire crfm_pkg::cfg_t cfg,
	output crfm_pkg::res_t      res
);

	logic [crfm_pkg::COUNT_W-1:0]      frame_pixels_q, frame_hits_q;
	logic [crfm_pkg::LINE_W-1:0]       row_hits_q, row_number_q;
	logic signed [crfm_pkg::TOP_W-1:0] found_top_q, ref_top_q;
	// Running negated frame count, negated reference count, and frame count minus reference count
	logic signed [crfm_pkg::DIFF_W-1:0] neg_hits_q, neg_ref_q, diff_q;

	logic                               hit, hits_inc, row_close, top_hit;
	logic [crfm_pkg::COUNT_W-1:0]       frame_pixels_nx, frame_hits_nx;
	logic [crfm_pkg::LINE_W-1:0]        row_hits_nx, this_row;
	logic signed [crfm_pkg::TOP_W-1:0]  found_top_nx;
	logic signed [crfm_pkg::DIFF_W-1:0] neg_hits_nx;

	// Classify the pixel against the three bands
	assign hit = (pix.blue  >= cfg.blue_low)  && (pix.blue  <= cfg.blue_high)  &&
	             (pix.green >= cfg.green_low) && (pix.green <= cfg.green_high) &&
	             (pix.red   >= cfg.red_low)   && (pix.red   <= cfg.red_high);

	// Advance saturating counters
	assign hits_inc        = hit && (frame_hits_q < crfm_pkg::FRAME_MAX);
	assign frame_hits_nx   = frame_hits_q + crfm_pkg::COUNT_W'(hits_inc);
	assign frame_pixels_nx = (frame_pixels_q < crfm_pkg::FRAME_MAX) ?
	                         frame_pixels_q + crfm_pkg::COUNT_W'(1) : crfm_pkg::FRAME_MAX;
	assign row_hits_nx     = (hit && (row_hits_q < crfm_pkg::COL_MAX)) ?
	                         row_hits_q + crfm_pkg::LINE_W'(1) : row_hits_q;
	assign neg_hits_nx     = neg_hits_q - crfm_pkg::DIFF_W'(hits_inc);

	// Close the row and latch the first qualifying one
	assign row_close = pix.row_end || pix.frame_end;
	assign this_row  = (row_number_q < crfm_pkg::ROW_MAX) ?
	                   row_number_q + crfm_pkg::LINE_W'(1) : crfm_pkg::ROW_MAX;
	assign top_hit   = row_close && found_top_q[crfm_pkg::TOP_W-1] &&
	                   (row_hits_nx >= cfg.row_hit_threshold);
	assign found_top_nx = top_hit ? crfm_pkg::TOP_W'({1'b0, this_row}) : found_top_q;

	// Form the frame result
	always_comb begin
		res.foliage_count = frame_hits_nx;
		res.pixel_total   = frame_pixels_nx;
		res.top_row       = found_top_nx;
		res.height_change = ref_top_q - found_top_nx;
		res.count_change  = diff_q + crfm_pkg::DIFF_W'(hits_inc);
	end

	// Hold state; clear per-frame state at frame end and take the reference when asked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= '0;
			frame_hits_q   <= '0;
			row_hits_q     <= '0;
			row_number_q   <= '0;
			found_top_q    <= '1;
			ref_top_q      <= '1;
			neg_hits_q     <= '0;
			neg_ref_q      <= '0;
			diff_q         <= '0;
		end else if (step) begin
			if (pix.frame_end) begin
				frame_pixels_q <= '0;
				frame_hits_q   <= '0;
				row_hits_q     <= '0;
				row_number_q   <= '0;
				found_top_q    <= '1;
				neg_hits_q     <= '0;
				if (pix.take_as_reference) begin
					ref_top_q <= found_top_nx;
					neg_ref_q <= neg_hits_nx;
					diff_q    <= neg_hits_nx;
				end else begin
					diff_q <= neg_ref_q;
				end
			end else begin
				frame_pixels_q <= frame_pixels_nx;
				frame_hits_q   <= frame_hits_nx;
				neg_hits_q     <= neg_hits_nx;
				diff_q         <= diff_q + crfm_pkg::DIFF_W'(hits_inc);
				found_top_q    <= found_top_nx;
				if (row_close) begin
					row_number_q <= this_row;
					row_hits_q   <= '0;
				end else begin
					row_hits_q <= row_hits_nx;
				end
			end
		end
	end

endmodule

`default_nettype wire
